// ===== rtl/gaussian_surface_level_set_defines.svh =====
// Assertion macros for the Gaussian surface level set block.
// Used by the top level; depends on nothing else.
`ifndef GAUSSIAN_SURFACE_LEVEL_SET_DEFINES_SVH
`define GAUSSIAN_SURFACE_LEVEL_SET_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define GSLS_ASSERT_IMP(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define GSLS_ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

// ===== rtl/gsls_pkg.sv =====
// Shared types, constants and the 2^f table for the level set block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gsls_pkg;

    localparam logic [23:0] SUM_MAX  = 24'hFFFFFF;
    localparam logic [23:0] SUM_STOP = 24'd98304;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] DECAY_RESET = 16'hE800;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        REG_DECAY = 1'b0,
        REG_COUNT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIST,
        ST_LAUNCH,
        ST_DIV,
        ST_EXP,
        ST_ACC,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_query;
        logic clear_acc;
        logic start_div;
        logic do_dist;
        logic do_exp;
        logic do_acc;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic exp_done;
        logic stop;
    } status_t;

    // 2^(i/depth) in Q1.16, from the exp series summed up to the x^14 term.
    function automatic logic [16:0] pow2_entry(input int unsigned i, input int unsigned depth);
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        logic [127:0] prod;
        x = ((64'(i)) * 64'd2977044472) / 64'(depth);
        sum = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 14; k++) begin
            prod = 128'(term) * 128'(x);
            term = 64'(prod >> 32) / 64'(k);
            sum = sum + term;
        end
        return 17'((sum + 64'd32768) >> 16);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gaussian_surface_level_set.sv =====
// Gaussian surface level set: top level, config registers, output register.
// Depends on gsls_pkg, gsls_ctrl, gsls_datapath and the defines header.
//
// Usage:
//  s_ channel takes items. operation=0 loads an atom (slot, x, y, z, size)
//  into the table and yields no result; operation=1 queries a
//  point and yields one result (level_value, saturated) on the m_ channel.
//  A query walks atom slots 0..min(atom_count, MAX_ATOMS)-1, stopping early
//  once the sum passes 1.5. Each atom goes through one RAM read, a distance
//  step, one divider launch, a 60-step bit-serial divider, three exp steps
//  and an accumulate.
//  One query is worked at a time. Loads are taken only while no query runs.
//  The result is held in a register until m_ready; while it waits the
//  block accepts no new item. Reset (aresetn low, synchronous) clears the
//  controller, restores decay_rate to -1.5 and atom_count to 0; the atom
//  table is not cleared and must be loaded before it is walked.
//  Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
//  taken; write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_surface_level_set_defines.svh"
module gaussian_surface_level_set import gsls_pkg::*; #(
    parameter int MAX_ATOMS       = 256,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_atom_slot,
    input  wire logic [19:0] s_pos_x,
    input  wire logic [19:0] s_pos_y,
    input  wire logic [19:0] s_pos_z,
    input  wire logic [11:0] s_atom_size,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [23:0]      m_level_value,
    output logic             m_saturated,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [15:0] decay_reg;
    logic [8:0]  count_reg;
    cmd_t        cmd;
    status_t     status;
    logic [$clog2(MAX_ATOMS)-1:0] rd_addr;
    logic        busy, res_valid, s_fire, load_we, start;

    assign cfg_ready = 1'b1;
    // hold config until written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= DECAY_RESET;
            count_reg <= '0;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_DECAY: decay_reg <= cfg_data;
                REG_COUNT: count_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !busy;
    assign s_fire  = s_valid && s_ready;
    assign load_we = s_fire && (op_t'(s_operation) == OP_LOAD);
    assign start   = s_fire && (op_t'(s_operation) == OP_QUERY);

    gsls_ctrl #(.MAX_ATOMS(MAX_ATOMS)) u_ctrl (
        .aclk, .aresetn, .start, .walk_len(count_reg), .status,
        .res_taken(m_ready), .cmd, .rd_addr, .busy, .res_valid
    );

    gsls_datapath #(.MAX_ATOMS(MAX_ATOMS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_dp (
        .aclk, .aresetn, .cmd, .status, .load_we, .load_slot(s_atom_slot),
        .in_x(s_pos_x), .in_y(s_pos_y), .in_z(s_pos_z), .in_size(s_atom_size),
        .rd_addr, .decay(signed'(decay_reg)), .acc_out(m_level_value),
        .sat_out(m_saturated)
    );

    assign m_valid = res_valid;

    `GSLS_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, m_valid, !s_ready, "item accepted while result pending")
    `GSLS_ASSERT_NEXT(a_result_drops, aclk, aresetn, m_valid && m_ready, !m_valid, "result repeated")
    `GSLS_ASSERT_NEXT(a_query_busy, aclk, aresetn, start, busy, "query did not start")
endmodule
`default_nettype wire

// ===== rtl/gsls_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gsls_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/gsls_datapath.sv =====
// Datapath: atom RAMs, distance, serial divider, exp and accumulator.
// Depends on gsls_pkg and gsls_ram.
`timescale 1ns / 1ps
`default_nettype none
module gsls_datapath import gsls_pkg::*; #(
    parameter int MAX_ATOMS       = 256,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire cmd_t                         cmd,
    output status_t                           status,
    input  wire logic                         load_we,
    input  wire logic [7:0]                   load_slot,
    input  wire logic [19:0]                  in_x,
    input  wire logic [19:0]                  in_y,
    input  wire logic [19:0]                  in_z,
    input  wire logic [11:0]                  in_size,
    input  wire logic [$clog2(MAX_ATOMS)-1:0] rd_addr,
    input  wire logic signed [15:0]           decay,
    output logic [23:0]                       acc_out,
    output logic                              sat_out
);
    localparam int AW = $clog2(MAX_ATOMS);
    localparam int TW = $clog2(EXP_TABLE_DEPTH);

    logic [19:0] ax, ay, az;
    logic [11:0] ar;
    logic        slot_ok;

    assign slot_ok = (32'(load_slot) < MAX_ATOMS);

    gsls_ram #(.WIDTH(20), .DEPTH(MAX_ATOMS)) u_x (.aclk, .we(load_we && slot_ok),
        .waddr(AW'(load_slot)), .wdata(in_x), .raddr(rd_addr), .rdata(ax));
    gsls_ram #(.WIDTH(20), .DEPTH(MAX_ATOMS)) u_y (.aclk, .we(load_we && slot_ok),
        .waddr(AW'(load_slot)), .wdata(in_y), .raddr(rd_addr), .rdata(ay));
    gsls_ram #(.WIDTH(20), .DEPTH(MAX_ATOMS)) u_z (.aclk, .we(load_we && slot_ok),
        .waddr(AW'(load_slot)), .wdata(in_z), .raddr(rd_addr), .rdata(az));
    gsls_ram #(.WIDTH(12), .DEPTH(MAX_ATOMS)) u_r (.aclk, .we(load_we && slot_ok),
        .waddr(AW'(load_slot)), .wdata(in_size), .raddr(rd_addr), .rdata(ar));

    // query point
    logic signed [19:0] qx_reg, qy_reg, qz_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            qx_reg <= in_x;
            qy_reg <= in_y;
            qz_reg <= in_z;
        end
    end

    // distance squared, radius squared
    logic signed [20:0] dx, dy, dz;
    logic [43:0] d2_reg;
    logic [23:0] r2_reg;
    assign dx = 21'(qx_reg) - 21'($signed(ax));
    assign dy = 21'(qy_reg) - 21'($signed(ay));
    assign dz = 21'(qz_reg) - 21'($signed(az));
    always_ff @(posedge aclk) begin
        if (cmd.do_dist) begin
            d2_reg <= 44'($unsigned(42'(dx) * 42'(dx))) + 44'($unsigned(42'(dy) * 42'(dy)))
                    + 44'($unsigned(42'(dz) * 42'(dz)));
            r2_reg <= (ar == 12'd0) ? 24'd1 : 24'(ar) * 24'(ar);
        end
    end

    // restoring divider: (d2 << 16) / r2, one quotient bit per cycle
    localparam int NW = 60;
    logic [NW-1:0] num_reg, num_next;
    logic [24:0]   rem_reg, rem_next;
    logic [5:0]    dcnt_reg;
    logic [24:0]   trial;
    logic          div_busy_reg;
    assign trial = {rem_reg[23:0], num_reg[NW-1]};
    always_comb begin
        num_next = {num_reg[NW-2:0], 1'b0};
        rem_next = trial;
        if (trial >= 25'(r2_reg)) begin
            rem_next = trial - 25'(r2_reg);
            num_next[0] = 1'b1;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            dcnt_reg <= '0;
        end else if (cmd.start_div) begin
            div_busy_reg <= 1'b1;
            dcnt_reg <= 6'(NW - 1);
            num_reg <= {d2_reg, 16'd0};
            rem_reg <= '0;
        end else if (div_busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            if (dcnt_reg == 6'd0) begin
                div_busy_reg <= 1'b0;
            end else begin
                dcnt_reg <= dcnt_reg - 6'd1;
            end
        end
    end
    assign status.div_done = !div_busy_reg && !cmd.start_div;

    // exp: stage 0 u and t, stage 1 w, stage 2 table and shift
    logic signed [35:0] u_c;
    logic signed [36:0] t_reg;
    logic signed [51:0] t_c;
    logic signed [54:0] w_reg;
    logic [1:0]         estep_reg;
    always_comb begin
        // clamp quotient to 2^18 + 1.0 (Q.16) before subtracting one
        if (num_reg > 60'd17179934720) u_c = 36'sd17179869184;
        else u_c = $signed({1'b0, num_reg[34:0]}) - 36'sd65536;
    end
    assign t_c = 52'(decay) * 52'(u_c);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            estep_reg <= '0;
        end else if (cmd.do_exp) begin
            estep_reg <= (estep_reg == 2'd2) ? 2'd0 : estep_reg + 2'd1;
            if (estep_reg == 2'd0) begin
                if (t_c > 52'sd6442450944) t_reg <= 37'sd6442450944;
                else if (t_c < -52'sd6442450944) t_reg <= -37'sd6442450944;
                else t_reg <= 37'(t_c);
            end else if (estep_reg == 2'd1) begin
                w_reg <= 55'(t_reg) * 55'(signed'({1'b0, LOG2E_Q16}));
            end
        end
    end
    assign status.exp_done = cmd.do_exp && (estep_reg == 2'd2);

    logic signed [10:0] n_c;
    logic [TW-1:0]      idx_c;
    logic [16:0]        mant_c;
    logic [23:0]        term_c;
    logic               term_sat;
    assign n_c = w_reg[54:44];
    assign idx_c = w_reg[43:44-TW];
    always_comb begin
        mant_c = '0;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            if (idx_c == TW'(i)) mant_c = pow2_entry(i, EXP_TABLE_DEPTH);
        end
    end
    always_comb begin
        term_sat = 1'b0;
        if (n_c >= 11'sd8) begin
            term_c = SUM_MAX;
            term_sat = 1'b1;
        end else if (n_c >= 11'sd0) begin
            term_c = 24'(mant_c) << n_c[2:0];
        end else if (n_c > -11'sd24) begin
            term_c = 24'(mant_c) >> 5'(-n_c);
        end else begin
            term_c = '0;
        end
    end
    logic [23:0] term_reg;
    logic        tsat_reg;
    always_ff @(posedge aclk) begin
        if (cmd.do_exp && estep_reg == 2'd2) begin
            term_reg <= term_c;
            tsat_reg <= term_sat;
        end
    end

    // accumulate with saturation
    logic [24:0] sum_c;
    logic [23:0] acc_reg;
    logic        sat_reg;
    assign sum_c = 25'(acc_reg) + 25'(term_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (cmd.clear_acc) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (cmd.do_acc) begin
            acc_reg <= sum_c[24] ? SUM_MAX : sum_c[23:0];
            sat_reg <= sat_reg | tsat_reg | sum_c[24];
        end
    end
    assign status.stop = acc_reg > SUM_STOP;
    assign acc_out = acc_reg;
    assign sat_out = sat_reg;
endmodule
`default_nettype wire

// ===== rtl/gsls_ctrl.sv =====
// Controller: walks the atom table for one query at a time.
// Depends on gsls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsls_ctrl import gsls_pkg::*; #(
    parameter int MAX_ATOMS = 256
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [8:0]                   walk_len,
    input  wire status_t                      status,
    input  wire logic                         res_taken,
    output cmd_t                              cmd,
    output logic [$clog2(MAX_ATOMS)-1:0]      rd_addr,
    output logic                              busy,
    output logic                              res_valid
);
    localparam int AW = $clog2(MAX_ATOMS);
    localparam int CW = $clog2(MAX_ATOMS + 1) > 9 ? $clog2(MAX_ATOMS + 1) : 9;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next, lim_reg, lim_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            lim_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            lim_reg <= lim_next;
        end
    end

    assign rd_addr = idx_reg[AW-1:0];

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        lim_next = lim_reg;
        cmd = '0;
        busy = 1'b1;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    cmd.load_query = 1'b1;
                    cmd.clear_acc = 1'b1;
                    idx_next = '0;
                    lim_next = (CW'(walk_len) > CW'(MAX_ATOMS)) ? CW'(MAX_ATOMS)
                             : CW'(walk_len);
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (idx_reg >= lim_reg || status.stop) state_next = ST_DONE;
                else state_next = ST_DIST;
            end
            ST_DIST: begin
                cmd.do_dist = 1'b1;
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                // launch the divider once the squared distance is registered
                cmd.start_div = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!status.div_done) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                cmd.do_exp = 1'b1;
                if (status.exp_done) state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.do_acc = 1'b1;
                idx_next = idx_reg + CW'(1);
                state_next = ST_READ;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_taken) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire
